// ----- rtl/kvot_pkg.sv -----
// Shared types and constants of the key/value option tokenizer.
`timescale 1ns / 1ps
package kvot_pkg;

  localparam int PhaseW = 4;

  // parse phases
  localparam logic [PhaseW-1:0] PH_BETWEEN   = 4'd0;
  localparam logic [PhaseW-1:0] PH_NAME      = 4'd1;
  localparam logic [PhaseW-1:0] PH_NAME_GAP  = 4'd2;
  localparam logic [PhaseW-1:0] PH_AFTER_EQ  = 4'd3;
  localparam logic [PhaseW-1:0] PH_PLAIN     = 4'd4;
  localparam logic [PhaseW-1:0] PH_PLAIN_ESC = 4'd5;
  localparam logic [PhaseW-1:0] PH_QUOTE     = 4'd6;
  localparam logic [PhaseW-1:0] PH_QUOTE_ESC = 4'd7;
  localparam logic [PhaseW-1:0] PH_DISCARD   = 4'd8;

  // token kinds
  localparam logic [2:0] TK_NAME  = 3'd0;
  localparam logic [2:0] TK_VALUE = 3'd1;
  localparam logic [2:0] TK_PAIR  = 3'd2;
  localparam logic [2:0] TK_OK    = 3'd3;
  localparam logic [2:0] TK_ERROR = 3'd4;

  // input kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [2:0] token_kind;
    logic       last;
  } token_t;

  // up to two tokens per input item
  typedef struct packed {
    logic [1:0]        count;
    token_t            tok0;
    token_t            tok1;
    logic [PhaseW-1:0] phase_next;
  } dec_t;

endpackage

// ----- rtl/kvot_if.sv -----
// Valid/ready channel interfaces for tokenizer input bytes and output tokens.
`timescale 1ns / 1ps
interface kvot_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink (input valid, input kind, input in_byte, output ready);
endinterface

interface kvot_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [2:0] token_kind;
  logic       last;

  modport source (output valid, output out_char, output token_kind, output last, input ready);
  modport sink (input valid, input out_char, input token_kind, input last, output ready);
endinterface

// ----- rtl/key_value_option_tokenizer_unit.sv -----
// Top level of the key/value option tokenizer.
`timescale 1ns / 1ps
// One option-string byte is taken per cycle into an input register while
// the input stage is not held; from that register its parse decision is
// made against the current phase and its tokens enter a four-entry output
// queue. The end-of-string item that closes a pending pair yields two
// tokens (pair end, done), so the output port, which moves one token per
// transaction, sets the sustained rate: one item per cycle while items give
// at most one token each and the output does not stall, and less where an
// item gives two tokens. The input stage holds whenever the queue lacks
// room for two tokens, which is how output stalls reach the input.
module key_value_option_tokenizer_unit (
  input  logic        clk,
  input  logic        rst,
  kvot_in_if.sink     in_ch,
  kvot_out_if.source  out_ch
);
  import kvot_pkg::*;

  logic              stage_valid;
  item_t             stage;
  logic [PhaseW-1:0] phase;
  dec_t              dec;
  logic [2:0]        level;
  logic              advance;
  logic              pop;
  logic [1:0]        push_count;

  assign pop        = out_ch.valid && out_ch.ready;
  // room for two tokens after this cycle's pop
  assign advance    = stage_valid && ((level - 3'(pop)) <= 3'd2);
  assign in_ch.ready = !stage_valid || advance;
  assign push_count = advance ? dec.count : 2'd0;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage.kind    <= in_ch.kind;
      stage.in_byte <= in_ch.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      phase       <= PH_BETWEEN;
    end else begin
      if (in_ch.ready) stage_valid <= in_ch.valid;
      if (advance) phase <= dec.phase_next;
    end
  end

  kvot_decode u_decode (
    .phase (phase),
    .item  (stage),
    .dec   (dec)
  );

  kvot_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .tok0       (dec.tok0),
    .tok1       (dec.tok1),
    .level      (level),
    .out_ch     (out_ch)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst) level <= 3'd4)
    else $error("token queue overflow");

  a_end_resets_phase: assert property (@(posedge clk) disable iff (rst)
    (advance && stage.kind == KIND_END) |=> (phase == PH_BETWEEN))
    else $error("phase not reset after end of string");

  a_end_gives_token: assert property (@(posedge clk) disable iff (rst)
    (advance && stage.kind == KIND_END) |=> out_ch.valid)
    else $error("end of string produced no token");

  a_held_when_full: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |=> stage_valid && $stable(stage))
    else $error("stalled input stage changed");

endmodule

// ----- rtl/kvot_decode.sv -----
// Per-byte parse decision: tokens produced and next parse phase.
`timescale 1ns / 1ps
module kvot_decode (
  input  logic [kvot_pkg::PhaseW-1:0] phase,
  input  kvot_pkg::item_t             item,
  output kvot_pkg::dec_t              dec
);
  import kvot_pkg::*;

  logic       blank;
  logic [7:0] b;
  token_t     t0;
  token_t     t1;
  logic [1:0] n;

  assign b     = item.in_byte;
  assign blank = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);

  always_comb begin
    n              = 2'd0;
    t0             = '0;
    t1             = '0;
    dec.phase_next = phase;
    if (item.kind == KIND_END) begin
      dec.phase_next = PH_BETWEEN;
      unique case (phase) inside
        PH_BETWEEN: begin
          n             = 2'd1;
          t0.token_kind = TK_OK;
        end
        PH_AFTER_EQ, PH_PLAIN, PH_PLAIN_ESC: begin
          n             = 2'd2;
          t0.token_kind = TK_PAIR;
          t1.token_kind = TK_OK;
        end
        default: begin
          n             = 2'd1;
          t0.token_kind = TK_ERROR;
        end
      endcase
    end else begin
      unique case (phase)
        PH_BETWEEN: begin
          if (blank) begin
          end else if (b == CH_EQ) begin
            dec.phase_next = PH_AFTER_EQ;
          end else begin
            n              = 2'd1;
            t0.out_char    = b;
            t0.token_kind  = TK_NAME;
            dec.phase_next = PH_NAME;
          end
        end
        PH_NAME: begin
          if (b == CH_EQ) begin
            dec.phase_next = PH_AFTER_EQ;
          end else if (blank) begin
            dec.phase_next = PH_NAME_GAP;
          end else begin
            n             = 2'd1;
            t0.out_char   = b;
            t0.token_kind = TK_NAME;
          end
        end
        PH_NAME_GAP: begin
          if (b == CH_EQ) begin
            dec.phase_next = PH_AFTER_EQ;
          end else if (!blank) begin
            dec.phase_next = PH_DISCARD;
          end
        end
        PH_AFTER_EQ: begin
          if (blank) begin
          end else if (b == CH_QUOTE) begin
            dec.phase_next = PH_QUOTE;
          end else if (b == CH_BSLASH) begin
            dec.phase_next = PH_PLAIN_ESC;
          end else begin
            n              = 2'd1;
            t0.out_char    = b;
            t0.token_kind  = TK_VALUE;
            dec.phase_next = PH_PLAIN;
          end
        end
        PH_PLAIN: begin
          if (blank) begin
            n              = 2'd1;
            t0.token_kind  = TK_PAIR;
            dec.phase_next = PH_BETWEEN;
          end else if (b == CH_BSLASH) begin
            dec.phase_next = PH_PLAIN_ESC;
          end else begin
            n             = 2'd1;
            t0.out_char   = b;
            t0.token_kind = TK_VALUE;
          end
        end
        PH_PLAIN_ESC: begin
          n              = 2'd1;
          t0.out_char    = b;
          t0.token_kind  = TK_VALUE;
          dec.phase_next = PH_PLAIN;
        end
        PH_QUOTE: begin
          if (b == CH_BSLASH) begin
            dec.phase_next = PH_QUOTE_ESC;
          end else if (b == CH_QUOTE) begin
            n              = 2'd1;
            t0.token_kind  = TK_PAIR;
            dec.phase_next = PH_BETWEEN;
          end else begin
            n             = 2'd1;
            t0.out_char   = b;
            t0.token_kind = TK_VALUE;
          end
        end
        PH_QUOTE_ESC: begin
          n              = 2'd1;
          t0.out_char    = b;
          t0.token_kind  = TK_VALUE;
          dec.phase_next = PH_QUOTE;
        end
        // discarding, and unreachable codes
        default: dec.phase_next = PH_DISCARD;
      endcase
    end
    t0.last   = (n == 2'd1);
    t1.last   = 1'b1;
    dec.count = n;
    dec.tok0  = t0;
    dec.tok1  = t1;
  end

endmodule

// ----- rtl/kvot_out_fifo.sv -----
// Four-entry token queue: takes up to two tokens a cycle, hands out one.
`timescale 1ns / 1ps
module kvot_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  kvot_pkg::token_t  tok0,
  input  kvot_pkg::token_t  tok1,
  output logic [2:0]        level,
  kvot_out_if.source        out_ch
);
  import kvot_pkg::*;

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  token_t          mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [2:0]      count;
  logic            pop;
  logic [PtrW-1:0] wr_ptr1;
  token_t          head;

  assign pop     = out_ch.valid && out_ch.ready;
  assign wr_ptr1 = wr_ptr + PtrW'(1);
  assign level   = count;
  assign head    = mem[rd_ptr];

  assign out_ch.valid      = (count != 3'd0);
  assign out_ch.out_char   = head.out_char;
  assign out_ch.token_kind = head.token_kind;
  assign out_ch.last       = head.last;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) mem[wr_ptr] <= tok0;
    if (push_count == 2'd2) mem[wr_ptr1] <= tok1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push_count);
      if (pop) rd_ptr <= rd_ptr + PtrW'(1);
      count  <= count + 3'(push_count) - 3'(pop);
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the key/value option tokenizer unit.
`timescale 1ns / 1ps
module tb_top;
  import kvot_pkg::*;

  localparam int          RESET_CYCLES   = 12;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          IDLE_LIMIT     = 3000;
  localparam int          RANDOM_ITEMS   = 1870;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [7:0]  CH_LF          = 8'h0A;
  localparam logic [7:0]  CH_VT          = 8'h0B;
  localparam logic [7:0]  CH_FF          = 8'h0C;

  logic clk = 1'b0;
  logic rst;

  kvot_in_if  in_ch ();
  kvot_out_if out_ch ();

  key_value_option_tokenizer_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow parse state and expected token stream
  logic [PhaseW-1:0] shadow_phase;
  token_t            expected_tokens [$];

  int  bad_tokens;
  int  tokens_checked;
  int  items_accepted;
  int  live_items;
  int  ends_accepted;
  int  strings_ok;
  int  strings_err;
  int  burst_left;
  bit  sender_gaps_on;
  bit  hold_request;
  bit  hold_active;
  bit  value_was_plain;

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic token_t mk_token(input logic [7:0] c, input logic [2:0] kd);
    token_t t;
    t.out_char   = c;
    t.token_kind = kd;
    t.last       = 1'b0;
    return t;
  endfunction

  // advance the shadow phase by one item and queue the tokens it yields
  function automatic void tokenize_item(input logic k, input logic [7:0] b);
    token_t toks [2];
    int     n;
    bit     bl;
    n  = 0;
    bl = is_blank(b);
    if (k == KIND_END) begin
      case (shadow_phase)
        PH_BETWEEN: begin
          toks[n] = mk_token(8'h00, TK_OK); n++;
        end
        PH_AFTER_EQ, PH_PLAIN, PH_PLAIN_ESC: begin
          toks[n] = mk_token(8'h00, TK_PAIR); n++;
          toks[n] = mk_token(8'h00, TK_OK); n++;
        end
        default: begin
          toks[n] = mk_token(8'h00, TK_ERROR); n++;
        end
      endcase
      shadow_phase = PH_BETWEEN;
    end else begin
      case (shadow_phase)
        PH_BETWEEN: begin
          if (bl) begin
          end else if (b == CH_EQ) begin
            shadow_phase = PH_AFTER_EQ;
          end else begin
            toks[n] = mk_token(b, TK_NAME); n++;
            shadow_phase = PH_NAME;
          end
        end
        PH_NAME: begin
          if (b == CH_EQ) begin
            shadow_phase = PH_AFTER_EQ;
          end else if (bl) begin
            shadow_phase = PH_NAME_GAP;
          end else begin
            toks[n] = mk_token(b, TK_NAME); n++;
          end
        end
        PH_NAME_GAP: begin
          if (b == CH_EQ) shadow_phase = PH_AFTER_EQ;
          else if (!bl) shadow_phase = PH_DISCARD;
        end
        PH_AFTER_EQ: begin
          if (bl) begin
          end else if (b == CH_QUOTE) begin
            shadow_phase = PH_QUOTE;
          end else if (b == CH_BSLASH) begin
            shadow_phase = PH_PLAIN_ESC;
          end else begin
            toks[n] = mk_token(b, TK_VALUE); n++;
            shadow_phase = PH_PLAIN;
          end
        end
        PH_PLAIN: begin
          if (bl) begin
            toks[n] = mk_token(8'h00, TK_PAIR); n++;
            shadow_phase = PH_BETWEEN;
          end else if (b == CH_BSLASH) begin
            shadow_phase = PH_PLAIN_ESC;
          end else begin
            toks[n] = mk_token(b, TK_VALUE); n++;
          end
        end
        PH_PLAIN_ESC: begin
          toks[n] = mk_token(b, TK_VALUE); n++;
          shadow_phase = PH_PLAIN;
        end
        PH_QUOTE: begin
          if (b == CH_BSLASH) begin
            shadow_phase = PH_QUOTE_ESC;
          end else if (b == CH_QUOTE) begin
            toks[n] = mk_token(8'h00, TK_PAIR); n++;
            shadow_phase = PH_BETWEEN;
          end else begin
            toks[n] = mk_token(b, TK_VALUE); n++;
          end
        end
        PH_QUOTE_ESC: begin
          toks[n] = mk_token(b, TK_VALUE); n++;
          shadow_phase = PH_QUOTE;
        end
        default: shadow_phase = PH_DISCARD;
      endcase
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) toks[i].last = 1'b1;
      if (toks[i].token_kind == TK_OK) strings_ok++;
      if (toks[i].token_kind == TK_ERROR) strings_err++;
      expected_tokens = {expected_tokens, toks[i]};
    end
  endfunction

  // input monitor feeds the shadow; output monitor checks against it
  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        items_accepted++;
        if (in_ch.kind == KIND_END) ends_accepted++;
        if (!(in_ch.kind == KIND_BYTE && shadow_phase == PH_DISCARD)) live_items++;
        tokenize_item(in_ch.kind, in_ch.in_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.out_char   = out_ch.out_char;
        got.token_kind = out_ch.token_kind;
        got.last       = out_ch.last;
        if (expected_tokens.size() == 0) begin
          bad_tokens++;
          if (bad_tokens <= MAX_REPORTS)
            $display("unexpected token: char %02h kind %0d last %0b",
                     got.out_char, got.token_kind, got.last);
        end else begin
          want = expected_tokens.pop_front();
          tokens_checked++;
          if (got.out_char !== want.out_char || got.token_kind !== want.token_kind ||
              got.last !== want.last) begin
            bad_tokens++;
            if (bad_tokens <= MAX_REPORTS)
              $display("token %0d mismatch: exp char %02h kind %0d last %0b, got char %02h kind %0d last %0b",
                       tokens_checked, want.out_char, want.token_kind, want.last,
                       got.out_char, got.token_kind, got.last);
          end
        end
      end
    end
  end

  // receiver: random stall segments, plus one long hold on request
  initial begin
    int seg_left;
    int stall_mode;
    out_ch.ready = 1'b0;
    seg_left     = 0;
    stall_mode   = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active  = 1'b0;
      end else begin
        if (seg_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          seg_left   = $urandom_range(20, 200);
        end
        case (stall_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= ~out_ch.ready;
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        seg_left--;
        @(posedge clk);
      end
    end
  end

  // no transaction on either side for too long ends the run
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // offer one item and hold it until accepted; valid stays high on return
  task automatic send_item(input logic k, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (sender_gaps_on && gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= k;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic sender_idle();
    in_ch.valid <= 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(KIND_BYTE, s[i]);
  endtask

  task automatic send_end();
    send_item(KIND_END, 8'($urandom_range(1, 255)));
  endtask

  function automatic logic [7:0] pick_blank();
    if ($urandom_range(0, 6) == 0) return CH_SPACE;
    return 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  function automatic logic [7:0] pick_any();
    case ($urandom_range(0, 19))
      0, 1:    return pick_blank();
      2:       return CH_EQ;
      3:       return CH_QUOTE;
      4:       return CH_BSLASH;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_name_char();
    logic [7:0] c;
    do c = pick_any(); while (is_blank(c) || c == CH_EQ);
    return c;
  endfunction

  function automatic logic [7:0] pick_plain_char(input bit first);
    logic [7:0] c;
    do c = pick_any(); while (is_blank(c) || c == CH_BSLASH || (first && c == CH_QUOTE));
    return c;
  endfunction

  function automatic logic [7:0] pick_quoted_char();
    logic [7:0] c;
    do c = pick_any(); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  task automatic send_name(input int len);
    for (int i = 0; i < len; i++) send_item(KIND_BYTE, pick_name_char());
  endtask

  task automatic send_quoted_body(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(KIND_BYTE, CH_BSLASH);
        send_item(KIND_BYTE, pick_any());
      end else begin
        send_item(KIND_BYTE, pick_quoted_char());
      end
    end
  endtask

  // one well-formed name=value pair with random content
  task automatic send_pair(input bit final_pair);
    int len;
    int vsel;
    if (value_was_plain) repeat ($urandom_range(1, 2)) send_item(KIND_BYTE, pick_blank());
    else repeat ($urandom_range(0, 2)) send_item(KIND_BYTE, pick_blank());
    len = $urandom_range(0, 5);
    send_name(len);
    if (len > 0 && $urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 2)) send_item(KIND_BYTE, pick_blank());
    send_item(KIND_BYTE, CH_EQ);
    if ($urandom_range(0, 3) == 0) send_item(KIND_BYTE, pick_blank());
    vsel = $urandom_range(0, 9);
    if (vsel <= 5) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(KIND_BYTE, CH_BSLASH);
          send_item(KIND_BYTE, pick_any());
        end else begin
          send_item(KIND_BYTE, pick_plain_char(i == 0));
        end
      end
      // backslash right before the end mark
      if (final_pair && $urandom_range(0, 9) == 0) send_item(KIND_BYTE, CH_BSLASH);
      value_was_plain = 1'b1;
    end else if (vsel <= 8 || !final_pair) begin
      send_item(KIND_BYTE, CH_QUOTE);
      send_quoted_body($urandom_range(0, 6));
      send_item(KIND_BYTE, CH_QUOTE);
      value_was_plain = 1'b0;
    end else begin
      value_was_plain = 1'b0;  // empty value closed by the end mark
    end
  endtask

  task automatic gen_string();
    int r;
    int npairs;
    r = $urandom_range(0, 99);
    value_was_plain = 1'b0;
    if (r < 80) begin
      npairs = $urandom_range(0, 4);
      for (int i = 0; i < npairs; i++) send_pair(i == npairs - 1);
    end else if (r < 92) begin
      npairs = $urandom_range(0, 2);
      for (int i = 0; i < npairs; i++) send_pair(1'b0);
      if (value_was_plain) send_item(KIND_BYTE, pick_blank());
      case ($urandom_range(0, 2))
        0: begin  // quote left open
          send_name($urandom_range(0, 3));
          send_item(KIND_BYTE, CH_EQ);
          send_item(KIND_BYTE, CH_QUOTE);
          send_quoted_body($urandom_range(0, 5));
          if ($urandom_range(0, 2) == 0) send_item(KIND_BYTE, CH_BSLASH);
        end
        1: begin  // name without '=', rest discarded
          send_name($urandom_range(1, 4));
          repeat ($urandom_range(1, 2)) send_item(KIND_BYTE, pick_blank());
          send_item(KIND_BYTE, pick_name_char());
          repeat ($urandom_range(0, 4)) send_item(KIND_BYTE, pick_any());
        end
        default: send_name($urandom_range(1, 4));  // name cut by the end mark
      endcase
    end else begin
      repeat ($urandom_range(0, 16)) send_item(KIND_BYTE, pick_any());
    end
    send_end();
  endtask

  task automatic test_directed_cases();
    // empty name, trailing backslash in a plain value
    send_item(KIND_BYTE, CH_SPACE);
    send_text("=\\");
    send_end();
    // top byte as name, escaped quote inside quotes, name right after the
    // closing quote, empty value before the end mark
    send_item(KIND_BYTE, CH_CR);
    send_item(KIND_BYTE, 8'hFF);
    send_text("='\\''k=");
    send_item(KIND_BYTE, CH_TAB);
    send_end();
    // quote inside a plain value is literal; dangling name discards the rest
    send_item(KIND_BYTE, 8'h01);
    send_text("=a'");
    send_item(KIND_BYTE, CH_LF);
    send_text("n");
    send_item(KIND_BYTE, CH_FF);
    send_text("xy");
    send_end();
    // name ended by the end mark
    send_text("n");
    send_end();
    // quote left open right after a backslash
    send_text("=");
    send_item(KIND_BYTE, CH_VT);
    send_text("'a\\");
    send_end();
  endtask

  task automatic test_output_backpressure();
    sender_idle();
    sender_gaps_on = 1'b0;
    hold_request   = 1'b1;
    while (!hold_active) @(posedge clk);
    // strings ending in two-token end marks, sent back to back while the output is held
    repeat (12) begin
      send_text("=ab");
      send_end();
    end
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_random_strings();
    int start_items;
    start_items = live_items;
    while (live_items - start_items < RANDOM_ITEMS) gen_string();
  endtask

  initial begin
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_BYTE;
    in_ch.in_byte   = 8'h01;
    shadow_phase    = PH_BETWEEN;
    bad_tokens      = 0;
    tokens_checked  = 0;
    items_accepted  = 0;
    live_items      = 0;
    ends_accepted   = 0;
    strings_ok      = 0;
    strings_err     = 0;
    burst_left      = 0;
    sender_gaps_on  = 1'b1;
    hold_request    = 1'b0;
    hold_active     = 1'b0;
    value_was_plain = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_output_backpressure();
    test_random_strings();

    sender_idle();
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    bad_tokens += expected_tokens.size();

    $display("run covered %0d input transactions over %0d strings, %0d tokens checked",
             items_accepted, ends_accepted, tokens_checked);
    $display("strings closed ok: %0d, closed with error: %0d, bad tokens: %0d",
             strings_ok, strings_err, bad_tokens);
    if (bad_tokens == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
